// ===== rtl/dls_pkg.sv =====
// Shared widths and default parameter values of the discrete log solver.
`default_nettype none
package dls_pkg;
    localparam int BASE_W           = 31;
    localparam int EXP_W            = 32;
    localparam int STEP_W           = 16;
    localparam int TABLE_SLOTS_DEF  = 65536;
    localparam int MODULUS_BITS_DEF = 31;
endpackage
`default_nettype wire

// ===== rtl/dls_query_if.sv =====
// Query channel of the discrete log solver: base, target and modulus.
`default_nettype none
interface dls_query_if import dls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base_value;
    logic [BASE_W-1:0] target_value;
    logic [BASE_W-1:0] modulus_value;

    modport source (output valid, output base_value, output target_value,
                    output modulus_value, input ready);
    modport sink   (input valid, input base_value, input target_value,
                    input modulus_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/dls_result_if.sv =====
// Result channel of the discrete log solver: found flag and exponent.
`default_nettype none
interface dls_result_if import dls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             solution_found;
    logic [EXP_W-1:0] exponent_result;

    modport source (output valid, output solution_found, output exponent_result,
                    input ready);
    modport sink   (input valid, input solution_found, input exponent_result,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/discrete_log_solver_core.sv =====
// Top level of the discrete log solver: sequencer, shared multiplier and storage.
// Each query returns the least x with base^x = target mod modulus, or not-found. The block
// takes one query at a time and stays not ready until its result is loaded into the output
// register. Every modular multiply runs through the registered multiplier and the bit-serial
// divider; the gcd reduction uses the same divider. A query that reaches the table phase
// runs a clearing pass over every slot of the hash store after the square root, then about
// 2*sqrt(p) modular multiplies and a linear probe per table access, so a modulus near 2^31
// takes far longer than small moduli or early special cases.
`default_nettype none
module discrete_log_solver_core import dls_pkg::*; #(
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dls_query_if.sink    query,
    dls_result_if.source result
);
    localparam int MB    = MODULUS_BITS;
    localparam int PW    = 2 * MB;
    localparam int NW    = (PW > BASE_W) ? PW : BASE_W;
    localparam int AW    = $clog2(TABLE_SLOTS);
    localparam int SQ_W  = (MB + 1) / 2;
    localparam int M_W   = SQ_W + 1;
    localparam int SB_W  = (SQ_W > 1) ? $clog2(SQ_W) : 1;
    localparam int PB_W  = $clog2(M_W);
    localparam int K_W   = $clog2(MB + 1);
    localparam int XW    = 2 * M_W + 2;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK0, S_AMOD, S_BMOD, S_GCD, S_GCD_R, S_BDIV, S_PDIV, S_ADIV,
        S_ADIVMOD, S_COEF, S_TBL, S_AR, S_SQ, S_SQM, S_SQC, S_M, S_CLR, S_BABY,
        S_INS, S_INS_W, S_BABY_NEXT, S_AM, S_PW_SQ, S_PW_SQR, S_PW_MR, S_PW_NEXT,
        S_GIANT, S_GNT, S_GNT_W, S_PRB_RD, S_PRB_CHK, S_MUL, S_MULD, S_DIV, S_FIN
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;
    logic [BASE_W-1:0] a_reg;
    logic [BASE_W-1:0] b_reg;
    logic [MB-1:0]     p_reg;
    logic [MB-1:0]     d_reg;
    logic [MB-1:0]     gx_reg;
    logic [MB-1:0]     gy_reg;
    logic [MB-1:0]     coef_reg;
    logic [MB-1:0]     ar_reg;
    logic [MB-1:0]     am_reg;
    logic [MB-1:0]     giant_reg;
    logic [MB-1:0]     pw_reg;
    logic [K_W-1:0]    k_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SB_W-1:0]   sq_bit_reg;
    logic [PB_W-1:0]   pw_bit_reg;
    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    j_reg;
    logic [M_W-1:0]    i_reg;
    logic [2*M_W-1:0]  im_reg;
    logic [MB-1:0]     mul_x_reg;
    logic [MB-1:0]     mul_y_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     prod;
    logic [AW-1:0]     clr_reg;
    logic [MB-1:0]     prb_key_reg;
    logic [AW-1:0]     prb_idx_reg;
    logic [AW-1:0]     prb_n_reg;
    logic              prb_ok_reg;
    logic              prb_used_reg;
    logic [STEP_W-1:0] prb_step_reg;
    logic              div_start_reg;
    logic [NW-1:0]     div_num_reg;
    logic [MB-1:0]     div_den_reg;
    logic              div_done;
    logic [NW-1:0]     div_quot;
    logic [MB-1:0]     div_rem;
    logic              wr_en_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic              wr_used_reg;
    logic [MB-1:0]     wr_key_reg;
    logic [STEP_W-1:0] wr_step_reg;
    logic              rd_used;
    logic [MB-1:0]     rd_key;
    logic [STEP_W-1:0] rd_step;
    logic              res_found_reg;
    logic [EXP_W-1:0]  res_exp_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [EXP_W-1:0]  out_exp_reg;
    logic [SQ_W-1:0]   sq_trial;
    logic [XW-1:0]     hit_exp;

    // Shared multiplier: operands and product are registered around it.
    assign prod     = PW'(mul_x_reg) * PW'(mul_y_reg);
    assign sq_trial = sq_reg | (SQ_W'(1) << sq_bit_reg);
    assign hit_exp  = XW'(im_reg) - XW'(prb_step_reg) + XW'(k_reg);

    dls_divider #(.N_W(NW), .D_W(MB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    dls_hash_store #(.SLOTS(TABLE_SLOTS), .KEY_W(MB)) u_store (
        .clk     (clk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_used (wr_used_reg),
        .wr_key  (wr_key_reg),
        .wr_step (wr_step_reg),
        .rd_addr (prb_idx_reg),
        .rd_used (rd_used),
        .rd_key  (rd_key),
        .rd_step (rd_step)
    );

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            div_start_reg <= 1'b0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            wr_en_reg     <= 1'b0;
            // A taken result leaves the output register unless a new one replaces it.
            if (result.valid && result.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (query.valid)
                    begin
                        a_reg     <= query.base_value;
                        b_reg     <= query.target_value;
                        p_reg     <= MB'(query.modulus_value);
                        coef_reg  <= MB'(1);
                        k_reg     <= '0;
                        state_reg <= S_CHECK0;
                    end
                end
                S_CHECK0:
                begin
                    if (p_reg == '0)
                    begin
                        res_found_reg <= 1'b0;
                        res_exp_reg   <= '0;
                        state_reg     <= S_FIN;
                    end
                    else if (p_reg == MB'(1))
                    begin
                        res_found_reg <= 1'b1;
                        res_exp_reg   <= '0;
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= NW'(a_reg);
                        div_den_reg   <= p_reg;
                        ret_reg       <= S_AMOD;
                        state_reg     <= S_DIV;
                    end
                end
                S_AMOD:
                begin
                    a_reg         <= BASE_W'(div_rem);
                    div_start_reg <= 1'b1;
                    div_num_reg   <= NW'(b_reg);
                    div_den_reg   <= p_reg;
                    ret_reg       <= S_BMOD;
                    state_reg     <= S_DIV;
                end
                S_BMOD:
                begin
                    b_reg <= BASE_W'(div_rem);
                    if (div_rem == MB'(1))
                    begin
                        res_found_reg <= 1'b1;
                        res_exp_reg   <= '0;
                        state_reg     <= S_FIN;
                    end
                    else if (a_reg == '0)
                    begin
                        res_found_reg <= (div_rem == '0);
                        res_exp_reg   <= (div_rem == '0) ? EXP_W'(1) : '0;
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        gx_reg    <= MB'(a_reg);
                        gy_reg    <= p_reg;
                        state_reg <= S_GCD;
                    end
                end
                // Euclid on (a, p), one remainder per divider pass.
                S_GCD:
                begin
                    if (gy_reg == '0)
                    begin
                        d_reg <= gx_reg;
                        if (gx_reg == MB'(1))
                        begin
                            state_reg <= S_TBL;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            div_num_reg   <= NW'(b_reg);
                            div_den_reg   <= gx_reg;
                            ret_reg       <= S_BDIV;
                            state_reg     <= S_DIV;
                        end
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= NW'(gx_reg);
                        div_den_reg   <= gy_reg;
                        ret_reg       <= S_GCD_R;
                        state_reg     <= S_DIV;
                    end
                end
                S_GCD_R:
                begin
                    gx_reg    <= gy_reg;
                    gy_reg    <= div_rem;
                    state_reg <= S_GCD;
                end
                S_BDIV:
                begin
                    if (div_rem != '0)
                    begin
                        res_found_reg <= 1'b0;
                        res_exp_reg   <= '0;
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        b_reg         <= BASE_W'(div_quot);
                        div_start_reg <= 1'b1;
                        div_num_reg   <= NW'(p_reg);
                        div_den_reg   <= d_reg;
                        ret_reg       <= S_PDIV;
                        state_reg     <= S_DIV;
                    end
                end
                S_PDIV:
                begin
                    p_reg         <= MB'(div_quot);
                    div_start_reg <= 1'b1;
                    div_num_reg   <= NW'(a_reg);
                    div_den_reg   <= d_reg;
                    ret_reg       <= S_ADIV;
                    state_reg     <= S_DIV;
                end
                S_ADIV:
                begin
                    div_start_reg <= 1'b1;
                    div_num_reg   <= div_quot;
                    div_den_reg   <= p_reg;
                    ret_reg       <= S_ADIVMOD;
                    state_reg     <= S_DIV;
                end
                S_ADIVMOD:
                begin
                    mul_x_reg <= coef_reg;
                    mul_y_reg <= div_rem;
                    ret_reg   <= S_COEF;
                    state_reg <= S_MUL;
                end
                S_COEF:
                begin
                    coef_reg <= div_rem;
                    k_reg    <= k_reg + 1'b1;
                    if (BASE_W'(div_rem) == b_reg)
                    begin
                        res_found_reg <= 1'b1;
                        res_exp_reg   <= EXP_W'(k_reg) + EXP_W'(1);
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        gx_reg    <= MB'(a_reg);
                        gy_reg    <= p_reg;
                        state_reg <= S_GCD;
                    end
                end
                // Table phase: reduce a, then the integer square root bit by bit.
                S_TBL:
                begin
                    div_start_reg <= 1'b1;
                    div_num_reg   <= NW'(a_reg);
                    div_den_reg   <= p_reg;
                    ret_reg       <= S_AR;
                    state_reg     <= S_DIV;
                end
                S_AR:
                begin
                    ar_reg     <= div_rem;
                    sq_reg     <= '0;
                    sq_bit_reg <= SB_W'(SQ_W - 1);
                    state_reg  <= S_SQ;
                end
                S_SQ:
                begin
                    mul_x_reg <= MB'(sq_trial);
                    mul_y_reg <= MB'(sq_trial);
                    state_reg <= S_SQM;
                end
                S_SQM:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_SQC;
                end
                S_SQC:
                begin
                    if (prod_reg <= PW'(p_reg))
                    begin
                        sq_reg <= SQ_W'(mul_x_reg);
                    end
                    if (sq_bit_reg == '0)
                    begin
                        state_reg <= S_M;
                    end
                    else
                    begin
                        sq_bit_reg <= sq_bit_reg - 1'b1;
                        state_reg  <= S_SQ;
                    end
                end
                S_M:
                begin
                    m_reg     <= M_W'(sq_reg) + M_W'(1);
                    clr_reg   <= '0;
                    state_reg <= S_CLR;
                end
                // Clearing pass: one slot per cycle.
                S_CLR:
                begin
                    wr_en_reg   <= 1'b1;
                    wr_addr_reg <= clr_reg;
                    wr_used_reg <= 1'b0;
                    wr_key_reg  <= '0;
                    wr_step_reg <= '0;
                    clr_reg     <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TABLE_SLOTS - 1))
                    begin
                        state_reg <= S_BABY;
                    end
                end
                S_BABY:
                begin
                    giant_reg <= MB'(b_reg);
                    j_reg     <= '0;
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    prb_key_reg <= giant_reg;
                    prb_idx_reg <= AW'(giant_reg);
                    prb_n_reg   <= '0;
                    ret_reg     <= S_INS_W;
                    state_reg   <= S_PRB_RD;
                end
                S_INS_W:
                begin
                    if (prb_ok_reg)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_addr_reg <= prb_idx_reg;
                        wr_used_reg <= 1'b1;
                        wr_key_reg  <= giant_reg;
                        wr_step_reg <= STEP_W'(j_reg);
                    end
                    if (j_reg == m_reg)
                    begin
                        state_reg <= S_AM;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        mul_x_reg <= giant_reg;
                        mul_y_reg <= ar_reg;
                        ret_reg   <= S_BABY_NEXT;
                        state_reg <= S_MUL;
                    end
                end
                S_BABY_NEXT:
                begin
                    giant_reg <= div_rem;
                    state_reg <= S_INS;
                end
                // a^m mod p, most significant exponent bit first.
                S_AM:
                begin
                    pw_reg     <= MB'(1);
                    pw_bit_reg <= PB_W'(M_W - 1);
                    state_reg  <= S_PW_SQ;
                end
                S_PW_SQ:
                begin
                    mul_x_reg <= pw_reg;
                    mul_y_reg <= pw_reg;
                    ret_reg   <= S_PW_SQR;
                    state_reg <= S_MUL;
                end
                S_PW_SQR:
                begin
                    pw_reg <= div_rem;
                    if (m_reg[pw_bit_reg])
                    begin
                        mul_x_reg <= div_rem;
                        mul_y_reg <= ar_reg;
                        ret_reg   <= S_PW_MR;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_PW_NEXT;
                    end
                end
                S_PW_MR:
                begin
                    pw_reg    <= div_rem;
                    state_reg <= S_PW_NEXT;
                end
                S_PW_NEXT:
                begin
                    if (pw_bit_reg == '0)
                    begin
                        state_reg <= S_GIANT;
                    end
                    else
                    begin
                        pw_bit_reg <= pw_bit_reg - 1'b1;
                        state_reg  <= S_PW_SQ;
                    end
                end
                // Giant steps: coefficient times a^m, then a lookup.
                S_GIANT:
                begin
                    am_reg    <= pw_reg;
                    i_reg     <= M_W'(1);
                    im_reg    <= (2*M_W)'(m_reg);
                    mul_x_reg <= coef_reg;
                    mul_y_reg <= pw_reg;
                    ret_reg   <= S_GNT;
                    state_reg <= S_MUL;
                end
                S_GNT:
                begin
                    coef_reg    <= div_rem;
                    prb_key_reg <= div_rem;
                    prb_idx_reg <= AW'(div_rem);
                    prb_n_reg   <= '0;
                    ret_reg     <= S_GNT_W;
                    state_reg   <= S_PRB_RD;
                end
                S_GNT_W:
                begin
                    if (prb_ok_reg && prb_used_reg)
                    begin
                        res_found_reg <= 1'b1;
                        res_exp_reg   <= EXP_W'(hit_exp);
                        state_reg     <= S_FIN;
                    end
                    else if (i_reg == m_reg)
                    begin
                        res_found_reg <= 1'b0;
                        res_exp_reg   <= '0;
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        im_reg    <= im_reg + (2*M_W)'(m_reg);
                        mul_x_reg <= coef_reg;
                        mul_y_reg <= am_reg;
                        ret_reg   <= S_GNT;
                        state_reg <= S_MUL;
                    end
                end
                // Linear probe: read a slot, check it on the next cycle.
                S_PRB_RD:
                begin
                    state_reg <= S_PRB_CHK;
                end
                S_PRB_CHK:
                begin
                    if (!rd_used || rd_key == prb_key_reg)
                    begin
                        prb_ok_reg   <= 1'b1;
                        prb_used_reg <= rd_used;
                        prb_step_reg <= rd_step;
                        state_reg    <= ret_reg;
                    end
                    else if (prb_n_reg == AW'(TABLE_SLOTS - 1))
                    begin
                        prb_ok_reg <= 1'b0;
                        state_reg  <= ret_reg;
                    end
                    else
                    begin
                        prb_idx_reg <= prb_idx_reg + 1'b1;
                        prb_n_reg   <= prb_n_reg + 1'b1;
                        state_reg   <= S_PRB_RD;
                    end
                end
                // Modular multiply: product, then reduction by the divider.
                S_MUL:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_MULD;
                end
                S_MULD:
                begin
                    div_start_reg <= 1'b1;
                    div_num_reg   <= NW'(prod_reg);
                    div_den_reg   <= p_reg;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= res_found_reg;
                        out_exp_reg   <= res_exp_reg;
                        state_reg     <= S_IDLE;
                    end
                    else if (result.valid && result.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign query.ready            = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.solution_found  = out_found_reg;
    assign result.exponent_result = out_exp_reg;

    // A query makes the block busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> !query.ready)
        else $error("block still ready after taking a query");

    // The divider finishes only while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    // A not-found result carries a zero exponent.
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.solution_found |-> result.exponent_result == '0)
        else $error("not-found result with nonzero exponent");

    // The clearing pass writes free slots only.
    a_clr_free: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == S_CLR) |-> wr_en_reg && !wr_used_reg)
        else $error("clearing pass wrote an occupied slot");
endmodule
`default_nettype wire

// ===== rtl/dls_divider.sv =====
// Bit-serial restoring divider shared by every modular step of the solver.
`default_nettype none
module dls_divider import dls_pkg::*; #(
    parameter int N_W = 62,
    parameter int D_W = 31
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic                done,
    output logic [N_W-1:0]      quot,
    output logic [D_W-1:0]      rem
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;

    // One quotient bit per cycle: shift in the next numerator bit and try to subtract.
    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[D_W])
                begin
                    rem_reg <= diff[D_W-1:0];
                    quo_reg <= {quo_reg[N_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[D_W-1:0];
                    quo_reg <= {quo_reg[N_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/dls_hash_store.sv =====
// Open-addressing hash store: used flag, residue key and baby-step index per slot.
`default_nettype none
module dls_hash_store import dls_pkg::*; #(
    parameter int SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_W = MODULUS_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire logic                     wr_used,
    input  wire logic [KEY_W-1:0]         wr_key,
    input  wire logic [STEP_W-1:0]        wr_step,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic                          rd_used,
    output logic [KEY_W-1:0]              rd_key,
    output logic [STEP_W-1:0]             rd_step
);
    localparam int ENT_W = 1 + KEY_W + STEP_W;

    logic [ENT_W-1:0] mem [SLOTS];
    logic [ENT_W-1:0] rd_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_used, wr_key, wr_step};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_used = rd_reg[ENT_W-1];
    assign rd_key  = rd_reg[ENT_W-2:STEP_W];
    assign rd_step = rd_reg[STEP_W-1:0];
endmodule
`default_nettype wire
